// ----- hw/rtl/bwnu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwnu_pkg
// Shared types and constants of the bilinear wrap noise upsampler: field
// widths, operation and register codes, corner codes, controller commands.
// ----------------------------------------------------------------------------
package bwnu_pkg;

    localparam int ROW_W   = 6;   // fine grid coordinate
    localparam int VAL_W   = 16;  // sample and result fraction
    localparam int DIM_W   = 7;   // grid size registers
    localparam int K_W     = 3;   // wavelength_log2
    localparam int SPAN_W  = 8;   // lattice spacing, up to 128
    localparam int WT_W    = 15;  // product of two blend weights, up to 128*128
    localparam int CFG_IDX_W = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAVELENGTH_LOG2 = 2'd2;

    localparam logic [DIM_W-1:0] RST_GRID_WIDTH      = 7'd64;
    localparam logic [DIM_W-1:0] RST_GRID_HEIGHT     = 7'd64;
    localparam logic [K_W-1:0]   RST_WAVELENGTH_LOG2 = 3'd0;

    typedef logic [1:0] corner_t;

    // A (row0,col0), B (row0,col1), C (row1,col0), D (row1,col1)
    localparam corner_t CORNER_A = 2'd0;
    localparam corner_t CORNER_B = 2'd1;
    localparam corner_t CORNER_C = 2'd2;
    localparam corner_t CORNER_D = 2'd3;

    typedef struct packed {
        logic    capture;   // latch the incoming item, clear accumulator
        logic    write;     // store a load item if it lies in the grid and on the lattice
        logic    rd_en;     // read one corner sample and its weight
        corner_t corner;
        logic    mac_en;    // accumulate the previous corner
        logic    out_load;  // move the rounded result to the output register
    } cmd_t;

    typedef struct packed {
        logic out_range;    // held query lies outside the grid
    } status_t;

endpackage

// ----- hw/rtl/bilinear_wrap_noise_upsampler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_wrap_noise_upsampler_core
// Loads coarse lattice samples and answers fine-cell queries by bilinear
// interpolation with wrap-around at the lattice edge.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries operation, row, col and
//   sample_value. A load transaction stores sample_value when (row, col) lies
//   inside the grid and on the lattice; it produces no result. A query
//   transaction produces one result on the output channel (out_valid/
//   out_stall): smoothed_value and out_of_range.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
//   always taken; issue them only while the block is idle.
// Sequencing:
//   One transaction is worked on at a time. A load captures and then
//   writes. An in-grid query reads the four corners in turn through the
//   single read port of the lattice memory, then takes one accumulate and
//   one output step; an out-of-grid query skips the reads. A result shows on
//   the output in the cycle after its output step.
// Reset: clears control state and restores grid 64x64, spacing 1; lattice
//   contents are undefined until loaded.
// Stall: a stalled result holds in the output register; the block accepts
//   and works on the next transaction meanwhile and waits only at hand-off.
// ----------------------------------------------------------------------------
module bilinear_wrap_noise_upsampler_core
    import bwnu_pkg::*;
#(
    parameter int MAX_DIM     = 64,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 operation,
    input  logic [ROW_W-1:0]     row,
    input  logic [ROW_W-1:0]     col,
    input  logic [VAL_W-1:0]     sample_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [VAL_W-1:0]     smoothed_value,
    output logic                 out_of_range
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    bwnu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .cmd       (cmd),
        .status    (status)
    );

    bwnu_datapath #(
        .MAX_DIM     (MAX_DIM),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .row            (row),
        .col            (col),
        .sample_value   (sample_value),
        .cmd            (cmd),
        .status         (status),
        .smoothed_value (smoothed_value),
        .out_of_range   (out_of_range)
    );

endmodule

// ----- hw/rtl/bwnu_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwnu_ctrl
// Controller: one transaction at a time: a load's write, or a query's four
// corner reads, final accumulate and hand-off to the output register.
// ----------------------------------------------------------------------------
module bwnu_ctrl
    import bwnu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    operation,
    output logic    in_stall,
    input  logic    out_stall,
    output logic    out_valid,
    output cmd_t    cmd,
    input  status_t status
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WRITE  = 5'b00010,
        ST_READ   = 5'b00100,
        ST_MAC    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t  state_reg, state_next;
    corner_t cnt_reg, cnt_next;
    logic    out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cnt_next    = CORNER_A;
                    state_next  = (operation == OP_LOAD) ? ST_WRITE : ST_READ;
                end
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (status.out_range)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.corner = cnt_reg;
                    // the sample read last cycle is ready to accumulate
                    cmd.mac_en = (cnt_reg != CORNER_A);
                    cnt_next   = cnt_reg + 2'd1;
                    if (cnt_reg == CORNER_D)
                    begin
                        state_next = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                cmd.mac_en = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= CORNER_A;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/bwnu_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwnu_datapath
// Datapath: configuration registers, held transaction, lattice memory,
// corner addressing with wrap, weight product, multiply-accumulate and
// rounding into the output register.
// ----------------------------------------------------------------------------
module bwnu_datapath
    import bwnu_pkg::*;
#(
    parameter int MAX_DIM     = 64,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic [ROW_W-1:0]     row,
    input  logic [ROW_W-1:0]     col,
    input  logic [VAL_W-1:0]     sample_value,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic [VAL_W-1:0]     smoothed_value,
    output logic                 out_of_range
);

    localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int ACC_W     = SAMPLE_BITS + WT_W;

    logic [DIM_W-1:0] grid_width_reg, grid_height_reg;
    logic [K_W-1:0]   k_reg;

    logic [ROW_W-1:0]       row_reg, col_reg;
    logic [SAMPLE_BITS-1:0] val_reg;

    logic [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [WT_W-1:0]        wt_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [VAL_W-1:0]       smoothed_reg;
    logic                   oor_reg;

    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [SPAN_W-1:0] span, mask;
    logic [ROW_W-1:0]  fy, fx, yi, xi, yf, xf, ry, rx;
    logic [SPAN_W-1:0] lh, lw, yi_inc, xi_inc, wy, wx;
    logic [2*SPAN_W-1:0] wt_full;
    logic              load_ok, out_range;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [ACC_W-1:0]  prod, half, rounded;
    logic [3:0]        shamt;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= RST_GRID_WIDTH;
            grid_height_reg <= RST_GRID_HEIGHT;
            k_reg           <= RST_WAVELENGTH_LOG2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:      grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT:     grid_height_reg <= cfg_data;
                REG_WAVELENGTH_LOG2: k_reg           <= cfg_data[K_W-1:0];
                default:             ;
            endcase
        end
    end

    // clamp grid sizes to 1..MAX_DIM
    always_comb
    begin
        priority if (grid_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (32'(grid_width_reg) > MAX_DIM)
            w_eff = DIM_W'(MAX_DIM);
        else
            w_eff = grid_width_reg;

        priority if (grid_height_reg == '0)
            h_eff = DIM_W'(1);
        else if (32'(grid_height_reg) > MAX_DIM)
            h_eff = DIM_W'(MAX_DIM);
        else
            h_eff = grid_height_reg;
    end

    // ---------------- held transaction ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg <= row;
            col_reg <= col;
            val_reg <= SAMPLE_BITS'(sample_value);
        end
    end

    // ---------------- lattice geometry ----------------
    always_comb
    begin
        span = SPAN_W'(1) << k_reg;
        mask = span - SPAN_W'(1);
        fy   = row_reg & mask[ROW_W-1:0];
        fx   = col_reg & mask[ROW_W-1:0];
        yi   = row_reg >> k_reg;
        xi   = col_reg >> k_reg;
        lh   = (SPAN_W'(h_eff) + mask) >> k_reg;
        lw   = (SPAN_W'(w_eff) + mask) >> k_reg;
        // next lattice row/column wraps to zero at the lattice edge
        yi_inc = SPAN_W'(yi) + SPAN_W'(1);
        xi_inc = SPAN_W'(xi) + SPAN_W'(1);
        yf     = (yi_inc == lh) ? '0 : yi_inc[ROW_W-1:0];
        xf     = (xi_inc == lw) ? '0 : xi_inc[ROW_W-1:0];

        out_range = (DIM_W'(row_reg) >= h_eff) || (DIM_W'(col_reg) >= w_eff);
        load_ok   = !out_range && (fy == '0) && (fx == '0);
    end

    assign status.out_range = out_range;

    always_comb
    begin
        unique case (cmd.corner)
            CORNER_A:
            begin
                ry = yi; rx = xi;
                wy = span - SPAN_W'(fy); wx = span - SPAN_W'(fx);
            end
            CORNER_B:
            begin
                ry = yi; rx = xf;
                wy = span - SPAN_W'(fy); wx = SPAN_W'(fx);
            end
            CORNER_C:
            begin
                ry = yf; rx = xi;
                wy = SPAN_W'(fy); wx = span - SPAN_W'(fx);
            end
            CORNER_D:
            begin
                ry = yf; rx = xf;
                wy = SPAN_W'(fy); wx = SPAN_W'(fx);
            end
            default:
            begin
                ry = yi; rx = xi;
                wy = '0; wx = '0;
            end
        endcase
    end

    assign wt_full = wy * wx;
    assign raddr   = ADDR_W'(32'(ry) * MAX_DIM + 32'(rx));
    assign waddr   = ADDR_W'(32'(yi) * MAX_DIM + 32'(xi));

    // ---------------- lattice memory ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.write && load_ok)
        begin
            mem[waddr] <= val_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // ---------------- multiply-accumulate ----------------
    assign prod = rd_data_reg * wt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            wt_reg <= wt_full[WT_W-1:0];
        end
        if (cmd.capture)
        begin
            acc_reg <= '0;
        end
        else if (cmd.mac_en)
        begin
            acc_reg <= acc_reg + prod;
        end
    end

    // round half up, then drop 2k fraction bits
    always_comb
    begin
        shamt   = {k_reg, 1'b0};
        half    = (k_reg == '0) ? '0 : (ACC_W'(1) << (shamt - 4'd1));
        rounded = (acc_reg + half) >> shamt;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            smoothed_reg <= out_range ? '0 : rounded[VAL_W-1:0];
            oor_reg      <= out_range;
        end
    end

    assign smoothed_value = smoothed_reg;
    assign out_of_range   = oor_reg;

endmodule

// ----- hw/rtl/bwnu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwnu_checker
// Port-level checks of the upsampler core, bound to the top level.
// ----------------------------------------------------------------------------
module bwnu_checker
    import bwnu_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             operation,
    input logic             out_valid,
    input logic             out_stall,
    input logic [VAL_W-1:0] smoothed_value,
    input logic             out_of_range
);

    // an out-of-grid result always carries a zero value
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> smoothed_value == '0)
        else $error("out_of_range result with nonzero value");

    // one transaction at a time: the input stalls right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted on consecutive cycles");

    // a load never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && operation == OP_LOAD && !out_valid |=> !out_valid)
        else $error("load transaction produced a result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(smoothed_value)
                                   && $stable(out_of_range))
        else $error("stalled result changed or dropped");

endmodule

bind bilinear_wrap_noise_upsampler_core bwnu_checker u_checker (.*);

// ----- test/bilinear_wrap_noise_upsampler_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_wrap_noise_upsampler_core_tb
// Self-checking bench for the lattice load / bilinear query core. A shadow
// lattice and register copy predict each query result, and every result is
// matched field by field against the oldest prediction. Directed tests hit
// edge blends, wrap, ignored loads, grid clamping and the widest spacing.
// Random phases then run under changing grid settings and handshake pressure.
// ----------------------------------------------------------------------------
module bilinear_wrap_noise_upsampler_core_tb;
    import bwnu_pkg::*;

    localparam int MAX_DIM       = 64;
    localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 105;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             out_of_range;
    } smoothed_t;

    typedef struct {
        int unsigned addr_a;
        int unsigned addr_b;
        int unsigned addr_c;
        int unsigned addr_d;
        int unsigned fy;
        int unsigned fx;
    } cell_geom_t;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [DIM_W-1:0]     cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic                 operation    = OP_LOAD;
    logic [ROW_W-1:0]     row          = '0;
    logic [ROW_W-1:0]     col          = '0;
    logic [VAL_W-1:0]     sample_value = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [VAL_W-1:0]     smoothed_value;
    logic                 out_of_range;

    // shadow of the block's registers and lattice
    logic [DIM_W-1:0] cfg_width  = RST_GRID_WIDTH;
    logic [DIM_W-1:0] cfg_height = RST_GRID_HEIGHT;
    logic [K_W-1:0]   cfg_wave   = RST_WAVELENGTH_LOG2;
    logic [VAL_W-1:0] lattice_shadow [0:STORE_DEPTH-1];
    bit               lattice_loaded [0:STORE_DEPTH-1];

    smoothed_t pending_results [$];

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int hold_requests   = 0;
    int hold_served     = 0;
    int hold_left       = 0;
    int error_count     = 0;

    bilinear_wrap_noise_upsampler_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .row            (row),
        .col            (col),
        .sample_value   (sample_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .smoothed_value (smoothed_value),
        .out_of_range   (out_of_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int unsigned active_size(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    function automatic cell_geom_t cell_geometry(input logic [ROW_W-1:0] at_row,
                                                 input logic [ROW_W-1:0] at_col);
        cell_geom_t  g;
        int unsigned k, s, lw, lh, yi, xi, yf, xf;
        k  = cfg_wave;
        s  = 1 << k;
        lw = (active_size(cfg_width) + s - 1) >> k;
        lh = (active_size(cfg_height) + s - 1) >> k;
        yi = at_row >> k;
        xi = at_col >> k;
        yf = (yi + 1) % lh;
        xf = (xi + 1) % lw;
        g.fy     = at_row & (s - 1);
        g.fx     = at_col & (s - 1);
        g.addr_a = yi * MAX_DIM + xi;
        g.addr_b = yi * MAX_DIM + xf;
        g.addr_c = yf * MAX_DIM + xi;
        g.addr_d = yf * MAX_DIM + xf;
        return g;
    endfunction

    function automatic smoothed_t interpolate_cell(input logic [ROW_W-1:0] at_row,
                                                   input logic [ROW_W-1:0] at_col);
        smoothed_t       r;
        cell_geom_t      g;
        int unsigned     k;
        longint unsigned s, a, b, c, d, top, bot, acc, half, rounded;
        r.value        = '0;
        r.out_of_range = 1'b0;
        if (at_row >= active_size(cfg_height) || at_col >= active_size(cfg_width))
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        g    = cell_geometry(at_row, at_col);
        k    = cfg_wave;
        s    = 64'd1 << k;
        a    = lattice_shadow[g.addr_a];
        b    = lattice_shadow[g.addr_b];
        c    = lattice_shadow[g.addr_c];
        d    = lattice_shadow[g.addr_d];
        top  = (s - g.fx) * a + g.fx * b;
        bot  = (s - g.fx) * c + g.fx * d;
        acc  = (s - g.fy) * top + g.fy * bot;
        half = (k > 0) ? (64'd1 << (2 * k - 1)) : 64'd0;
        rounded = (acc + half) >> (2 * k);
        r.value = rounded[VAL_W-1:0];
        return r;
    endfunction

    // Returns 1 when the transaction has an effect: a kept load or any query.
    function automatic bit commit_item(input logic             op_code,
                                       input logic [ROW_W-1:0] at_row,
                                       input logic [ROW_W-1:0] at_col,
                                       input logic [VAL_W-1:0] value);
        int unsigned k, s, addr;
        k = cfg_wave;
        s = 1 << k;
        if (op_code == OP_LOAD)
        begin
            if (at_row < active_size(cfg_height) && at_col < active_size(cfg_width) &&
                (at_row & (s - 1)) == 0 && (at_col & (s - 1)) == 0)
            begin
                addr = (at_row >> k) * MAX_DIM + (at_col >> k);
                lattice_shadow[addr] = value;
                lattice_loaded[addr] = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end
        pending_results.push_back(interpolate_cell(at_row, at_col));
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic send_item(input  logic             op_code,
                             input  logic [ROW_W-1:0] at_row,
                             input  logic [ROW_W-1:0] at_col,
                             input  logic [VAL_W-1:0] value,
                             output bit               counted);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op_code;
        row          <= at_row;
        col          <= at_col;
        sample_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        counted = commit_item(op_code, at_row, at_col, value);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // let a trailing load finish
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_GRID_WIDTH:      cfg_width  = data;
            REG_GRID_HEIGHT:     cfg_height = data;
            REG_WAVELENGTH_LOG2: cfg_wave   = data[K_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [DIM_W-1:0] width_data,
                             input logic [DIM_W-1:0] height_data,
                             input logic [DIM_W-1:0] wave_data);
        wait_for_drain();
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, DIM_W'($urandom));
        write_reg(REG_GRID_WIDTH, width_data);
        write_reg(REG_GRID_HEIGHT, height_data);
        write_reg(REG_WAVELENGTH_LOG2, wave_data);
        cfg_valid <= 1'b0;
    endtask

    // Load whatever corners of the cell are still missing, then query it.
    task automatic issue_cell_query(input  logic [ROW_W-1:0] at_row,
                                    input  logic [ROW_W-1:0] at_col,
                                    output int               n);
        cell_geom_t  g;
        int unsigned corner_addr [4];
        int unsigned k;
        bit          counted;
        g = cell_geometry(at_row, at_col);
        k = cfg_wave;
        corner_addr[0] = g.addr_a;
        corner_addr[1] = g.addr_b;
        corner_addr[2] = g.addr_c;
        corner_addr[3] = g.addr_d;
        n = 0;
        for (int i = 0; i < 4; i++)
        begin
            if (!lattice_loaded[corner_addr[i]])
            begin
                send_item(OP_LOAD, ROW_W'((corner_addr[i] / MAX_DIM) << k),
                          ROW_W'((corner_addr[i] % MAX_DIM) << k), VAL_W'($urandom),
                          counted);
                n += counted;
            end
        end
        send_item(OP_QUERY, at_row, at_col, VAL_W'($urandom), counted);
        n += counted;
    endtask

    task automatic issue_random_item(output int n);
        int unsigned      pick, w, h, k, lw, lh;
        bit               counted;
        logic [ROW_W-1:0] r, c;
        w    = active_size(cfg_width);
        h    = active_size(cfg_height);
        k    = cfg_wave;
        lw   = (w + (1 << k) - 1) >> k;
        lh   = (h + (1 << k) - 1) >> k;
        pick = $urandom_range(99);
        n    = 0;
        if (pick < 50 || (pick < 60 && w == MAX_DIM && h == MAX_DIM))
        begin
            r = ROW_W'($urandom_range(h - 1));
            c = ROW_W'($urandom_range(w - 1));
            issue_cell_query(r, c, n);
        end
        else if (pick < 60)
        begin
            if (h < MAX_DIM && (w == MAX_DIM || $urandom_range(1) == 1))
            begin
                r = ROW_W'($urandom_range(MAX_DIM - 1, h));
                c = ROW_W'($urandom_range(MAX_DIM - 1));
            end
            else
            begin
                r = ROW_W'($urandom_range(MAX_DIM - 1));
                c = ROW_W'($urandom_range(MAX_DIM - 1, w));
            end
            send_item(OP_QUERY, r, c, VAL_W'($urandom), counted);
            n = counted;
        end
        else if (pick < 85)
        begin
            r = ROW_W'($urandom_range(lh - 1) << k);
            c = ROW_W'($urandom_range(lw - 1) << k);
            send_item(OP_LOAD, r, c, VAL_W'($urandom), counted);
            n = counted;
        end
        else
        begin
            // noise: mostly off lattice or outside the grid
            send_item(OP_LOAD, ROW_W'($urandom), ROW_W'($urandom), VAL_W'($urandom),
                      counted);
            n = counted;
        end
    endtask

    task automatic run_random_phase(input int item_goal);
        int               done, n;
        logic [DIM_W-1:0] w, h;
        logic [K_W-1:0]   k;
        case ($urandom_range(5))
            0:
            begin
                w = 7'd64;
                h = 7'd64;
            end
            1:
            begin
                w = 7'd1;
                h = 7'd1;
            end
            2:
            begin
                w = 7'd0;
                h = 7'd127;
            end
            3:
            begin
                w = DIM_W'($urandom_range(127, 65));
                h = DIM_W'($urandom_range(64));
            end
            default:
            begin
                w = DIM_W'($urandom_range(64, 1));
                h = DIM_W'($urandom_range(64, 1));
            end
        endcase
        k = K_W'($urandom_range(7));
        configure(w, h, {4'($urandom_range(15)), k});
        done = 0;
        while (done < item_goal)
        begin
            issue_random_item(n);
            done += n;
        end
    endtask

    task automatic test_reset_defaults();
        bit counted;
        sender_idle_pct = 0;
        stall_pct       = 0;
        send_item(OP_LOAD, 6'd0, 6'd0, 16'hFFFF, counted);
        send_item(OP_LOAD, 6'd0, 6'd1, 16'h0000, counted);
        send_item(OP_LOAD, 6'd1, 6'd0, 16'h1234, counted);
        send_item(OP_LOAD, 6'd1, 6'd1, 16'h8001, counted);
        send_item(OP_LOAD, 6'd63, 6'd63, 16'h0001, counted);
        send_item(OP_LOAD, 6'd63, 6'd0, 16'hFFFE, counted);
        send_item(OP_LOAD, 6'd0, 6'd63, 16'h7FFF, counted);
        send_item(OP_QUERY, 6'd0, 6'd0, 16'hFFFF, counted);
        // corner of the grid wraps to row and column 0
        send_item(OP_QUERY, 6'd63, 6'd63, 16'h0000, counted);
    endtask

    task automatic test_lattice_blend();
        bit counted;
        configure(7'd8, 7'd8, 7'd2);
        send_item(OP_LOAD, 6'd0, 6'd0, 16'hFFFF, counted);
        send_item(OP_LOAD, 6'd0, 6'd4, 16'h0000, counted);
        send_item(OP_LOAD, 6'd4, 6'd0, 16'h8000, counted);
        send_item(OP_LOAD, 6'd4, 6'd4, 16'h0001, counted);
        // dropped: off lattice, then on lattice but outside the grid
        send_item(OP_LOAD, 6'd1, 6'd1, 16'hAAAA, counted);
        send_item(OP_LOAD, 6'd8, 6'd0, 16'h5555, counted);
        send_item(OP_QUERY, 6'd0, 6'd0, 16'h0000, counted);
        send_item(OP_QUERY, 6'd2, 6'd2, 16'h0000, counted);
        send_item(OP_QUERY, 6'd3, 6'd1, 16'h0000, counted);
        send_item(OP_QUERY, 6'd7, 6'd7, 16'h0000, counted);
        send_item(OP_QUERY, 6'd8, 6'd3, 16'h0000, counted);
        send_item(OP_QUERY, 6'd63, 6'd63, 16'hFFFF, counted);
    endtask

    task automatic test_spacing_extremes();
        bit counted;
        // width 0 acts as 1, height 127 as 64, spacing 128
        configure(7'd0, 7'd127, 7'd7);
        send_item(OP_LOAD, 6'd0, 6'd0, 16'h5A5A, counted);
        send_item(OP_QUERY, 6'd63, 6'd0, 16'h0000, counted);
        send_item(OP_QUERY, 6'd0, 6'd0, 16'h0000, counted);
        send_item(OP_QUERY, 6'd0, 6'd1, 16'h0000, counted);
    endtask

    task automatic test_output_holdoff();
        int n;
        sender_idle_pct = 0;
        stall_pct       = 0;
        configure(7'd16, 7'd16, 7'd2);
        hold_requests++;
        for (int i = 0; i < 20; i++)
            issue_cell_query(ROW_W'($urandom_range(15)), ROW_W'($urandom_range(15)), n);
        wait_for_drain();
        for (int i = 0; i < 10; i++)
            issue_cell_query(ROW_W'($urandom_range(15)), ROW_W'($urandom_range(15)), n);
    endtask

    task automatic test_random_no_idle();
        sender_idle_pct = 0;
        stall_pct       = 0;
        repeat (4) run_random_phase(PHASE_ITEMS);
    endtask

    task automatic test_random_sender_idle();
        sender_idle_pct = 56;
        stall_pct       = 0;
        repeat (4) run_random_phase(PHASE_ITEMS);
    endtask

    task automatic test_random_receiver_stall();
        sender_idle_pct = 0;
        stall_pct       = 56;
        repeat (4) run_random_phase(PHASE_ITEMS);
    endtask

    task automatic test_random_both_idle();
        sender_idle_pct = 18;
        stall_pct       = 18;
        repeat (4) run_random_phase(PHASE_ITEMS);
    endtask

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        smoothed_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no transaction pending", smoothed_value, 0);
            else
            begin
                want = pending_results.pop_front();
                if (smoothed_value !== want.value)
                    report_mismatch("smoothed_value", smoothed_value, want.value);
                if (out_of_range !== want.out_of_range)
                    report_mismatch("out_of_range", out_of_range, want.out_of_range);
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_lattice_blend();
        test_spacing_extremes();
        test_output_holdoff();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        wait_for_drain();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
